// File: rtl/escd_pkg.sv
// Package for the escape sequence decoder: request types, decoder state,
// character codes and limits shared by the decode logic, top level and checker.
// No dependencies.
package escd_pkg;

  // Largest number of results that one input request can cause
  localparam int unsigned MaxRes = 6;
  localparam int unsigned ResCntW = $clog2(MaxRes + 1);
  localparam int unsigned ResIdxW = $clog2(MaxRes);
  // Hex digits kept for replaying a surrogate escape
  localparam int unsigned NumDigits = 4;

  // Character codes
  localparam logic [15:0] ChBslash = 16'h005C;
  localparam logic [15:0] ChLowerN = 16'h006E;
  localparam logic [15:0] ChLowerR = 16'h0072;
  localparam logic [15:0] ChLowerT = 16'h0074;
  localparam logic [15:0] ChLowerX = 16'h0078;
  localparam logic [15:0] ChLowerU = 16'h0075;
  localparam logic [15:0] ChLf     = 16'h000A;
  localparam logic [15:0] ChCr     = 16'h000D;
  localparam logic [15:0] ChTab    = 16'h0009;

  // Surrogate code unit range
  localparam logic [15:0] SurrLo = 16'hD800;
  localparam logic [15:0] SurrHi = 16'hDFFF;

  // Digit limits per escape kind
  localparam logic [2:0] MaxDigitsX = 3'd2;
  localparam logic [2:0] MaxDigitsU = 3'd4;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_BSLASH = 2'd1,
    PH_HEX    = 2'd2
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic        kind_u;
    logic [15:0] value;
    logic [2:0]  count;
  } dec_state_t;

  typedef logic [NumDigits-1:0][6:0] digit_chars_t;
  typedef logic [MaxRes-1:0][15:0]   res_list_t;

  typedef struct packed {
    logic [15:0] in_char;
    logic        is_final;
  } in_req_t;

  typedef struct packed {
    logic [15:0] out_char;
    logic        run_last;
    logic        string_end;
  } out_req_t;

endpackage

// File: rtl/escape_sequence_decoder.sv
// Top level of the C-style escape sequence decoder: escape state registers
// and the result buffer that drains one character per cycle unless stalled.
// Depends on escd_pkg and escd_decode.
//
// The decoder takes one UTF-16 code unit per request and returns its decoded
// characters one per cycle while out_stall_i is low, the first of them in the
// cycle after the request is taken. Plain text thus streams at one character
// per clock; a request that causes several results (up to six, for a surrogate
// \u escape replayed as text) holds off further requests until they drain,
// and the next request is taken in the cycle its last result leaves. The result
// buffer is loaded in one go and shifted out. run_last marks the final result
// of each request and string_end the final result of a string. A request that
// only opens or extends an escape returns nothing.
module escape_sequence_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  escd_pkg::in_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output escd_pkg::out_req_t out_req_o
);

  escd_pkg::dec_state_t         state_q, state_d;
  escd_pkg::digit_chars_t       chars_q, chars_d;
  escd_pkg::res_list_t          buf_q, res_list;
  logic [escd_pkg::ResCntW-1:0] left_q, res_cnt;
  logic                         fin_q;
  logic                         in_take;
  logic                         out_take;

  escd_decode u_decode (
    .req_i     (in_req_i),
    .state_i   (state_q),
    .chars_i   (chars_q),
    .state_o   (state_d),
    .chars_o   (chars_d),
    .res_o     (res_list),
    .res_cnt_o (res_cnt)
  );

  // Take a request once the buffer is empty or its last result is leaving
  assign in_stall_o  = (left_q > 1) || (left_q == 1 && out_stall_i);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_valid_o = (left_q != '0);
  assign out_take    = out_valid_o && !out_stall_i;

  // Escape state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: escd_pkg::PH_NORMAL, kind_u: 1'b0, value: '0, count: '0};
    end else if (in_take) begin
      state_q <= state_d;
    end
  end

  // Hex digit characters, only read after being written in the same escape
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      chars_q <= chars_d;
    end
  end

  // Result count and string end flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      fin_q  <= 1'b0;
    end else if (in_take) begin
      left_q <= res_cnt;
      fin_q  <= in_req_i.is_final;
    end else if (out_take) begin
      left_q <= left_q - 1'b1;
    end
  end

  // Load the result list, shift it down as results leave
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      buf_q <= res_list;
    end else if (out_take) begin
      buf_q <= escd_pkg::res_list_t'(buf_q >> 16);
    end
  end

  assign out_req_o.out_char   = buf_q[0];
  assign out_req_o.run_last   = (left_q == 1);
  assign out_req_o.string_end = (left_q == 1) && fin_q;

endmodule

// File: rtl/escd_decode.sv
// Combinational decode of one input character against the escape state.
// Produces the next state and the list of result characters for the request.
// Depends on escd_pkg.
module escd_decode (
  input  escd_pkg::in_req_t                  req_i,
  input  escd_pkg::dec_state_t               state_i,
  input  escd_pkg::digit_chars_t             chars_i,
  output escd_pkg::dec_state_t               state_o,
  output escd_pkg::digit_chars_t             chars_o,
  output escd_pkg::res_list_t                res_o,
  output logic [escd_pkg::ResCntW-1:0]       res_cnt_o
);

  logic [15:0]                  c;
  logic                         is_hex;
  logic [3:0]                   dig;
  logic [2:0]                   max_digits;
  logic [15:0]                  letter;
  logic                         surrogate;
  logic                         do_fin;
  logic                         emit_c;
  logic [15:0]                  c_val;
  logic                         tail_bs;
  escd_pkg::dec_state_t         st;
  escd_pkg::digit_chars_t       ch;
  escd_pkg::res_list_t          res;
  logic [escd_pkg::ResCntW-1:0] n;

  assign c = req_i.in_char;

  // Classify the character as a hex digit
  always_comb begin
    is_hex = 1'b0;
    dig    = c[3:0];
    if (c >= 16'h0030 && c <= 16'h0039) begin
      is_hex = 1'b1;
    end else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046)) begin
      is_hex = 1'b1;
      dig    = c[3:0] + 4'd9;
    end
  end

  assign max_digits = state_i.kind_u ? escd_pkg::MaxDigitsU : escd_pkg::MaxDigitsX;

  // Advance the escape state and decide what this request emits
  always_comb begin
    st      = state_i;
    ch      = chars_i;
    do_fin  = 1'b0;
    emit_c  = 1'b0;
    c_val   = c;
    tail_bs = 1'b0;
    case (state_i.phase)
      escd_pkg::PH_BSLASH: begin
        st.phase = escd_pkg::PH_NORMAL;
        emit_c   = 1'b1;
        if (c == escd_pkg::ChLowerN) begin
          c_val = escd_pkg::ChLf;
        end else if (c == escd_pkg::ChLowerR) begin
          c_val = escd_pkg::ChCr;
        end else if (c == escd_pkg::ChLowerT) begin
          c_val = escd_pkg::ChTab;
        end else if (c == escd_pkg::ChLowerX || c == escd_pkg::ChLowerU) begin
          emit_c    = 1'b0;
          st.phase  = escd_pkg::PH_HEX;
          st.kind_u = (c == escd_pkg::ChLowerU);
          st.value  = '0;
          st.count  = '0;
        end
      end
      escd_pkg::PH_HEX: begin
        if (is_hex) begin
          st.value                  = {state_i.value[11:0], dig};
          ch[state_i.count[1:0]]    = c[6:0];
          st.count                  = state_i.count + 3'd1;
          if (st.count >= max_digits) begin
            do_fin   = 1'b1;
            st.phase = escd_pkg::PH_NORMAL;
          end
        end else begin
          // Close the pending escape, then treat the terminator as plain text
          do_fin = 1'b1;
          if (c == escd_pkg::ChBslash) begin
            st.phase = escd_pkg::PH_BSLASH;
          end else begin
            st.phase = escd_pkg::PH_NORMAL;
            emit_c   = 1'b1;
          end
        end
      end
      default: begin
        if (c == escd_pkg::ChBslash) begin
          st.phase = escd_pkg::PH_BSLASH;
        end else begin
          st.phase = escd_pkg::PH_NORMAL;
          emit_c   = 1'b1;
        end
      end
    endcase

    // Flush whatever is pending at the end of the string
    if (req_i.is_final) begin
      if (st.phase == escd_pkg::PH_BSLASH) begin
        tail_bs = 1'b1;
      end else if (st.phase == escd_pkg::PH_HEX) begin
        do_fin = 1'b1;
      end
      st.phase = escd_pkg::PH_NORMAL;
    end
  end

  assign letter    = st.kind_u ? escd_pkg::ChLowerU : escd_pkg::ChLowerX;
  assign surrogate = (st.value >= escd_pkg::SurrLo) && (st.value <= escd_pkg::SurrHi);

  // Pack the results in order: closed escape, plain character, trailing backslash
  always_comb begin
    res = '0;
    n   = '0;
    if (do_fin) begin
      if (st.count == 3'd0 || surrogate) begin
        res[n[escd_pkg::ResIdxW-1:0]] = escd_pkg::ChBslash;
        n = n + 1'b1;
        res[n[escd_pkg::ResIdxW-1:0]] = letter;
        n = n + 1'b1;
        if (surrogate) begin
          for (int k = 0; k < escd_pkg::NumDigits; k++) begin
            if (3'(k) < st.count) begin
              res[n[escd_pkg::ResIdxW-1:0]] = {9'd0, ch[k]};
              n = n + 1'b1;
            end
          end
        end
      end else begin
        res[n[escd_pkg::ResIdxW-1:0]] = st.value;
        n = n + 1'b1;
      end
    end
    if (emit_c) begin
      res[n[escd_pkg::ResIdxW-1:0]] = c_val;
      n = n + 1'b1;
    end
    if (tail_bs) begin
      res[n[escd_pkg::ResIdxW-1:0]] = escd_pkg::ChBslash;
      n = n + 1'b1;
    end
  end

  assign state_o   = st;
  assign chars_o   = ch;
  assign res_o     = res;
  assign res_cnt_o = n;

endmodule

// File: rtl/escd_checker.sv
// Port-level checker for the escape sequence decoder, bound to the top level.
// Depends on escd_pkg and escape_sequence_decoder.
module escd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input escd_pkg::in_req_t  in_req_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input escd_pkg::out_req_t out_req_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed or vanished");

  // The string end only falls on the last result of a request
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.string_end |-> out_req_o.run_last)
    else $error("string_end without run_last");

  // Hold back new requests while a run is still draining
  a_run_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_req_o.run_last |-> in_stall_o)
    else $error("request taken in the middle of a run");

  // Hold back new requests while the output is stalled
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("request taken while output stalled");

  // Drop valid after the last result leaves with no new request
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_req_o.run_last && !(in_valid_i && !in_stall_o)
    |=> !out_valid_o)
    else $error("result invented after run ended");

endmodule

bind escape_sequence_decoder escd_checker u_escd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);

// File: test/escape_sequence_decoder_tb.sv
// Testbench for escape_sequence_decoder: a queue-fed request driver, a result
// monitor with random stall, and a local escape decoder that predicts every result.
// Depends on escd_pkg and the escape_sequence_decoder RTL.
module escape_sequence_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import escd_pkg::*;

  localparam logic [15:0] ChQuote  = 16'h0027;
  localparam logic [15:0] ChDquote = 16'h0022;
  localparam int unsigned NumRandom = 250;
  localparam int unsigned MaxReports = 10;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_req;

  // Pending text and decoded characters still owed by the block
  in_req_t  text_q[$];
  out_req_t decoded_q[$];
  int unsigned text_total = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 8;
  int unsigned recv_stall_pct = 71;

  // Local decoder state
  phase_e       dec_phase = PH_NORMAL;
  logic         dec_kind_u = 1'b0;
  logic [15:0]  dec_value = '0;
  logic [2:0]   dec_count = '0;
  digit_chars_t dec_digits = '0;
  logic [15:0]  run_chars[$];

  escape_sequence_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_req_o  (out_req)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("escape_sequence_decoder: mismatch");
    $finish;
  end

  function automatic int hex_nibble(logic [15:0] c);
    if (c >= 16'h0030 && c <= 16'h0039) return int'(c - 16'h0030);
    if (c >= 16'h0061 && c <= 16'h0066) return int'(c - 16'h0061) + 10;
    if (c >= 16'h0041 && c <= 16'h0046) return int'(c - 16'h0041) + 10;
    return -1;
  endfunction

  // Emit a finished hex escape: its value, or its own text when it cannot stand
  function void close_hex();
    logic [15:0] letter;
    letter = dec_kind_u ? ChLowerU : ChLowerX;
    if (dec_count == 0) begin
      run_chars.insert(run_chars.size(), ChBslash);
      run_chars.insert(run_chars.size(), letter);
    end else if (dec_value >= SurrLo && dec_value <= SurrHi) begin
      run_chars.insert(run_chars.size(), ChBslash);
      run_chars.insert(run_chars.size(), letter);
      for (int k = 0; k < dec_count && k < NumDigits; k++)
        run_chars.insert(run_chars.size(), {9'd0, dec_digits[k]});
    end else begin
      run_chars.insert(run_chars.size(), dec_value);
    end
    dec_phase = PH_NORMAL;
  endfunction

  function void take_plain(logic [15:0] c);
    if (c == ChBslash) dec_phase = PH_BSLASH;
    else run_chars.insert(run_chars.size(), c);
  endfunction

  // Decode one accepted request and queue the characters it owes
  function void decode_escape(in_req_t r);
    int          d;
    logic [2:0]  max_digits;
    out_req_t    res;
    run_chars.delete();
    case (dec_phase)
      PH_BSLASH: begin
        dec_phase = PH_NORMAL;
        case (r.in_char)
          ChLowerN: run_chars.insert(run_chars.size(), ChLf);
          ChLowerR: run_chars.insert(run_chars.size(), ChCr);
          ChLowerT: run_chars.insert(run_chars.size(), ChTab);
          ChLowerX, ChLowerU: begin
            dec_phase  = PH_HEX;
            dec_kind_u = (r.in_char == ChLowerU);
            dec_value  = '0;
            dec_count  = '0;
          end
          default: run_chars.insert(run_chars.size(), r.in_char);
        endcase
      end
      PH_HEX: begin
        d = hex_nibble(r.in_char);
        max_digits = dec_kind_u ? MaxDigitsU : MaxDigitsX;
        if (d >= 0) begin
          dec_value = {dec_value[11:0], d[3:0]};
          dec_digits[dec_count[1:0]] = r.in_char[6:0];
          dec_count = dec_count + 3'd1;
          if (dec_count >= max_digits) close_hex();
        end else begin
          close_hex();
          take_plain(r.in_char);
        end
      end
      default: begin
        dec_phase = PH_NORMAL;
        take_plain(r.in_char);
      end
    endcase
    // Flush whatever is pending at the end of the string
    if (r.is_final) begin
      if (dec_phase == PH_BSLASH) run_chars.insert(run_chars.size(), ChBslash);
      else if (dec_phase == PH_HEX) close_hex();
      dec_phase = PH_NORMAL;
    end
    while (run_chars.size() > MaxRes) void'(run_chars.pop_back());
    foreach (run_chars[k]) begin
      res.out_char   = run_chars[k];
      res.run_last   = (k == run_chars.size() - 1);
      res.string_end = res.run_last && r.is_final;
      decoded_q.insert(decoded_q.size(), res);
    end
  endfunction

  function void flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReports) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // Request driver: hold a stalled request, advance or idle otherwise
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req   <= '0;
    end else begin
      if (in_valid && !in_stall) decode_escape(in_req);
      if (!in_valid || !in_stall) begin
        if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_req   <= text_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest one owed
  always @(posedge clk_i or negedge rst_ni) begin
    out_req_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          flag_error($sformatf("unexpected result char=%h last=%b end=%b",
                               out_req.out_char, out_req.run_last, out_req.string_end));
        end else begin
          want = decoded_q.pop_front();
          if (out_req.out_char !== want.out_char || out_req.run_last !== want.run_last ||
              out_req.string_end !== want.string_end)
            flag_error($sformatf("exp char=%h last=%b end=%b, got char=%h last=%b end=%b",
                                 want.out_char, want.run_last, want.string_end,
                                 out_req.out_char, out_req.run_last, out_req.string_end));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_unit(logic [15:0] c, logic fin);
    in_req_t r;
    r.in_char  = c;
    r.is_final = fin;
    text_q.insert(text_q.size(), r);
    text_total++;
  endtask

  task automatic push_text(string s, logic fin);
    for (int i = 0; i < s.len(); i++)
      push_unit({8'h00, s[i]}, fin && (i == s.len() - 1));
  endtask

  function automatic logic [15:0] hex_char(int v);
    if (v < 10) return 16'h0030 + 16'(v);
    return ($urandom_range(1) ? 16'h0061 : 16'h0041) + 16'(v - 10);
  endfunction

  function automatic logic [15:0] plain_char();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(16'h007E, 16'h0020));
  endfunction

  function automatic logic [15:0] simple_letter();
    case ($urandom_range(6))
      0: return ChLowerN;
      1: return ChLowerR;
      2: return ChLowerT;
      3: return ChBslash;
      4: return ChQuote;
      5: return ChDquote;
      default: return plain_char();
    endcase
  endfunction

  // Build one string of plain text and well-formed or truncated escapes
  task automatic add_string();
    logic [15:0] units[$];
    int          n_tok;
    int          pick;
    int          n_dig;
    logic        fin;
    n_tok = $urandom_range(8, 1);
    repeat (n_tok) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        units.insert(units.size(), plain_char());
      end else if (pick < 55) begin
        units.insert(units.size(), ChBslash);
        units.insert(units.size(), simple_letter());
      end else if (pick < 90) begin
        units.insert(units.size(), ChBslash);
        units.insert(units.size(), pick < 72 ? ChLowerX : ChLowerU);
        n_dig = $urandom_range(pick < 72 ? 2 : 4, 0);
        repeat (n_dig) units.insert(units.size(), hex_char($urandom_range(15)));
      end else begin
        // \u value inside the surrogate range
        units.insert(units.size(), ChBslash);
        units.insert(units.size(), ChLowerU);
        units.insert(units.size(), hex_char(13));
        units.insert(units.size(), hex_char($urandom_range(15, 8)));
        units.insert(units.size(), hex_char($urandom_range(15)));
        units.insert(units.size(), hex_char($urandom_range(15)));
      end
    end
    fin = ($urandom_range(9) != 0);
    foreach (units[k])
      push_unit(units[k], (k == units.size() - 1) ? fin : ($urandom_range(19) == 0));
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (text_q.size() != 0 || in_valid || decoded_q.size() != 0);
  endtask

  initial begin
    int unsigned base;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme code units, surrogate replay, full and missing digits,
    // non-hex terminator opening a new escape, flushes and trailing backslash
    push_unit(16'h0000, 1'b0);
    push_unit(16'hFFFF, 1'b1);
    push_text("\\uD83d", 1'b0);
    push_text("\\x4F", 1'b0);
    push_text("\\xG", 1'b0);
    push_text("\\u1\\q", 1'b0);
    push_text("\\u", 1'b1);
    push_text("\\", 1'b1);
    base = text_total;

    // Sender mostly busy, receiver mostly stalled
    while (text_total < base + NumRandom / 3) add_string();
    wait_drained();

    // Sender mostly idle, receiver mostly ready
    send_idle_pct  = 71;
    recv_stall_pct = 8;
    while (text_total < base + 2 * NumRandom / 3) add_string();
    wait_drained();

    // Full rate on both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (text_total < base + NumRandom) add_string();
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (decoded_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", decoded_q.size()));
    if (mismatch_count == 0) begin
      $display("escape_sequence_decoder: match");
    end else begin
      $display("escape_sequence_decoder: mismatch");
    end
    $finish;
  end

endmodule
